FILE: rtl/oled_i2c_pkg.sv
`default_nettype none

package oled_i2c_pkg;

   // register reset values
   localparam logic [7:0]  DEFAULT_DEVICE_ADDRESS = 8'h78;
   localparam logic [15:0] DEFAULT_TICKS_PER_WAIT = 16'd1;

   // configuration port
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TICKS_PER_WAIT = 1'b1;

   // queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   // framing bytes
   localparam logic [7:0] CTRL_COMMAND = 8'h00;
   localparam logic [7:0] CTRL_DATA    = 8'h40;
   localparam logic [7:0] PAGE_CMD     = 8'hB0;
   localparam logic [7:0] COL_HIGH_CMD = 8'h10;

   // request codes, same encoding as the func field
   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_COMMAND = 2'd1,
      OP_DATA    = 2'd2,
      OP_CURSOR  = 2'd3
   } op_kind_type;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] value;
      logic [2:0] page;
      logic [6:0] column;
   } req_payload_type;

   typedef struct packed {
      logic scl;
      logic sda;
      logic busy_res;
      logic rejected;
      logic done_res;
   } rsp_payload_type;

   // classified word handed from front to back
   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
   } q_entry_type;

endpackage

`default_nettype wire

FILE: rtl/oled_i2c_front.sv
`default_nettype none

module oled_i2c_front #(
   parameter int unsigned Depth = oled_i2c_pkg::QUEUE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire oled_i2c_pkg::req_payload_type req_payload,
   output logic                               q_valid,
   output oled_i2c_pkg::q_entry_type          q_entry,
   input  wire logic                          q_pop
);

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(Depth);

   oled_i2c_pkg::q_entry_type q_ff [Depth];
   oled_i2c_pkg::q_entry_type word_class;
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic push;
   logic pop;

   // classify the incoming word and build its payload bytes
   always_comb begin
      word_class.byte0 = req_payload.value;
      word_class.byte1 = 8'h00;
      word_class.byte2 = 8'h00;
      unique case (req_payload.func)
         oled_i2c_pkg::OP_TICK:    word_class.kind = oled_i2c_pkg::OP_TICK;
         oled_i2c_pkg::OP_COMMAND: word_class.kind = oled_i2c_pkg::OP_COMMAND;
         oled_i2c_pkg::OP_DATA:    word_class.kind = oled_i2c_pkg::OP_DATA;
         default: begin
            word_class.kind  = oled_i2c_pkg::OP_CURSOR;
            word_class.byte0 = oled_i2c_pkg::PAGE_CMD | {5'd0, req_payload.page};
            word_class.byte1 = oled_i2c_pkg::COL_HIGH_CMD | {5'd0, req_payload.column[6:4]};
            word_class.byte2 = {4'd0, req_payload.column[3:0]};
         end
      endcase
   end

   // queue control
   assign req_ready = (count_ff != CntFull);
   assign q_valid   = (count_ff != '0);
   assign q_entry   = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= word_class;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntFull)
      else $error("queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (count_ff != '0))
      else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: rtl/oled_i2c_back.sv
`default_nettype none

module oled_i2c_back (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         csr_we,
   input  wire logic [oled_i2c_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [oled_i2c_pkg::CSR_DATA_WIDTH-1:0]      csr_wdata,
   input  wire logic                                         q_valid,
   input  wire oled_i2c_pkg::q_entry_type                    q_entry,
   output logic                                              q_pop,
   output logic                                              rsp_valid,
   input  wire logic                                         rsp_ready,
   output oled_i2c_pkg::rsp_payload_type                     rsp_payload
);

   typedef enum logic [1:0] {
      POS_START_HI,
      POS_START_LO,
      POS_BITS,
      POS_STOP
   } pos_type;

   localparam logic [1:0] BYTE_ADDRESS = 2'd0;
   localparam logic [1:0] BYTE_CONTROL = 2'd1;
   localparam logic [1:0] BYTE_PAYLOAD = 2'd2;
   localparam logic [3:0] BIT_LAST     = 4'd7;
   localparam logic [3:0] BIT_ACK      = 4'd8;
   localparam logic [1:0] PHASE_LOW    = 2'd0;
   localparam logic [1:0] PHASE_HIGH   = 2'd1;
   localparam logic [1:0] PHASE_FALL   = 2'd2;
   localparam logic [1:0] TXN_LAST_CURSOR = 2'd2;

   logic [7:0]  device_address_ff, device_address_in;
   logic [15:0] ticks_per_wait_ff, ticks_per_wait_in;

   pos_type     pos_ff, pos_in;
   logic        busy_ff, busy_in;
   logic [15:0] wait_ff, wait_in;
   logic [1:0]  byte_idx_ff, byte_idx_in;
   logic [3:0]  bit_ff, bit_in;
   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  txn_ff, txn_in;
   logic        cursor_ff, cursor_in;
   logic        data_mode_ff, data_mode_in;
   logic [7:0]  payload_ff [3];
   logic [7:0]  payload_in [3];
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        rsp_valid_ff, rsp_valid_in;
   oled_i2c_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic        fire;
   logic        is_req;
   logic        rejected;
   logic        done;
   logic [15:0] wait_load;
   logic [1:0]  txn_last;
   logic [1:0]  nb_idx;
   logic [2:0]  nb_bit;
   logic [7:0]  payload_sel;
   logic [7:0]  tx_byte;
   logic        tx_bit;

   // configuration writes
   always_comb begin
      device_address_in = device_address_ff;
      ticks_per_wait_in = ticks_per_wait_ff;
      if (csr_we) begin
         unique case (csr_index)
            oled_i2c_pkg::CSR_DEVICE_ADDRESS: device_address_in = csr_wdata[7:0];
            default:                          ticks_per_wait_in = csr_wdata;
         endcase
      end
   end

   assign wait_load = (ticks_per_wait_ff == 16'd0) ? 16'd1 : ticks_per_wait_ff;
   assign txn_last  = cursor_ff ? TXN_LAST_CURSOR : 2'd0;

   // handshake: a word leaves the queue when the output stage is free
   assign fire   = q_valid && (!rsp_valid_ff || rsp_ready);
   assign q_pop  = fire;
   assign is_req = (q_entry.kind != oled_i2c_pkg::OP_TICK);

   // which data bit the next low phase puts on sda
   always_comb begin
      if (pos_ff == POS_START_LO) begin
         nb_idx = BYTE_ADDRESS;
         nb_bit = 3'd0;
      end else if (bit_ff == BIT_ACK) begin
         nb_idx = byte_idx_ff + 1'b1;
         nb_bit = 3'd0;
      end else begin
         nb_idx = byte_idx_ff;
         nb_bit = bit_ff[2:0] + 1'b1;
      end
   end

   always_comb begin
      unique case (txn_ff)
         2'd0:    payload_sel = payload_ff[0];
         2'd1:    payload_sel = payload_ff[1];
         2'd2:    payload_sel = payload_ff[2];
         default: payload_sel = 8'h00;
      endcase
   end

   always_comb begin
      unique case (nb_idx)
         BYTE_ADDRESS: tx_byte = device_address_ff;
         BYTE_CONTROL: tx_byte = data_mode_ff ? oled_i2c_pkg::CTRL_DATA
                                              : oled_i2c_pkg::CTRL_COMMAND;
         BYTE_PAYLOAD: tx_byte = payload_sel;
         default:      tx_byte = 8'h00;
      endcase
   end

   assign tx_bit = tx_byte[3'd7 - nb_bit];

   // sequencer: one step of the bus waveform per expired wait
   always_comb begin
      pos_in       = pos_ff;
      busy_in      = busy_ff;
      wait_in      = wait_ff;
      byte_idx_in  = byte_idx_ff;
      bit_in       = bit_ff;
      phase_in     = phase_ff;
      txn_in       = txn_ff;
      cursor_in    = cursor_ff;
      data_mode_in = data_mode_ff;
      for (int i = 0; i < 3; i++) begin
         payload_in[i] = payload_ff[i];
      end
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      rejected = 1'b0;
      done     = 1'b0;

      if (fire) begin
         if (is_req && !busy_ff) begin
            // load a new operation and show start-high
            payload_in[0] = q_entry.byte0;
            payload_in[1] = q_entry.byte1;
            payload_in[2] = q_entry.byte2;
            cursor_in     = (q_entry.kind == oled_i2c_pkg::OP_CURSOR);
            data_mode_in  = (q_entry.kind == oled_i2c_pkg::OP_DATA);
            txn_in        = 2'd0;
            busy_in       = 1'b1;
            pos_in        = POS_START_HI;
            byte_idx_in   = BYTE_ADDRESS;
            bit_in        = 4'd0;
            phase_in      = PHASE_LOW;
            scl_in        = 1'b1;
            sda_in        = 1'b1;
            wait_in       = wait_load;
         end else begin
            rejected = is_req;
            if (busy_ff) begin
               if (wait_ff > 16'd1) begin
                  wait_in = wait_ff - 16'd1;
               end else begin
                  wait_in = wait_load;
                  unique case (pos_ff)
                     POS_START_HI: begin
                        pos_in = POS_START_LO;
                        sda_in = 1'b0;
                     end
                     POS_START_LO: begin
                        pos_in      = POS_BITS;
                        byte_idx_in = BYTE_ADDRESS;
                        bit_in      = 4'd0;
                        phase_in    = PHASE_LOW;
                        scl_in      = 1'b0;
                        sda_in      = tx_bit;
                     end
                     POS_BITS: begin
                        if (bit_ff == BIT_ACK) begin
                           if (byte_idx_ff == BYTE_PAYLOAD) begin
                              pos_in = POS_STOP;
                              scl_in = 1'b1;
                              sda_in = 1'b0;
                           end else begin
                              byte_idx_in = nb_idx;
                              bit_in      = 4'd0;
                              phase_in    = PHASE_LOW;
                              scl_in      = 1'b0;
                              sda_in      = tx_bit;
                           end
                        end else if (phase_ff == PHASE_FALL) begin
                           if (bit_ff == BIT_LAST) begin
                              // ack clock, sda untouched
                              bit_in = BIT_ACK;
                              scl_in = 1'b1;
                           end else begin
                              bit_in   = {1'b0, nb_bit};
                              phase_in = PHASE_LOW;
                              scl_in   = 1'b0;
                              sda_in   = tx_bit;
                           end
                        end else if (phase_ff == PHASE_LOW) begin
                           phase_in = PHASE_HIGH;
                           scl_in   = 1'b1;
                        end else begin
                           phase_in = PHASE_FALL;
                           scl_in   = 1'b0;
                        end
                     end
                     default: begin
                        if (txn_ff < txn_last) begin
                           // next transaction of a cursor set
                           txn_in      = txn_ff + 1'b1;
                           pos_in      = POS_START_HI;
                           byte_idx_in = BYTE_ADDRESS;
                           bit_in      = 4'd0;
                           phase_in    = PHASE_LOW;
                           scl_in      = 1'b1;
                           sda_in      = 1'b1;
                        end else begin
                           // release sda, operation complete
                           scl_in      = 1'b1;
                           sda_in      = 1'b1;
                           busy_in     = 1'b0;
                           byte_idx_in = BYTE_ADDRESS;
                           bit_in      = 4'd0;
                           phase_in    = PHASE_LOW;
                           wait_in     = 16'd0;
                           done        = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
      end
   end

   // output stage
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (fire) begin
         rsp_valid_in            = 1'b1;
         rsp_payload_in.scl      = scl_in;
         rsp_payload_in.sda      = sda_in;
         rsp_payload_in.busy_res = busy_in;
         rsp_payload_in.rejected = rejected;
         rsp_payload_in.done_res = done;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= oled_i2c_pkg::DEFAULT_DEVICE_ADDRESS;
         ticks_per_wait_ff <= oled_i2c_pkg::DEFAULT_TICKS_PER_WAIT;
         pos_ff            <= POS_START_HI;
         busy_ff           <= 1'b0;
         wait_ff           <= 16'd0;
         byte_idx_ff       <= BYTE_ADDRESS;
         bit_ff            <= 4'd0;
         phase_ff          <= PHASE_LOW;
         txn_ff            <= 2'd0;
         cursor_ff         <= 1'b0;
         data_mode_ff      <= 1'b0;
         scl_ff            <= 1'b1;
         sda_ff            <= 1'b1;
         rsp_valid_ff      <= 1'b0;
      end else begin
         device_address_ff <= device_address_in;
         ticks_per_wait_ff <= ticks_per_wait_in;
         pos_ff            <= pos_in;
         busy_ff           <= busy_in;
         wait_ff           <= wait_in;
         byte_idx_ff       <= byte_idx_in;
         bit_ff            <= bit_in;
         phase_ff          <= phase_in;
         txn_ff            <= txn_in;
         cursor_ff         <= cursor_in;
         data_mode_ff      <= data_mode_in;
         scl_ff            <= scl_in;
         sda_ff            <= sda_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         payload_ff[i] <= payload_in[i];
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   a_wait_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (wait_ff != 16'd0))
      else $error("busy with an empty wait counter");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && pos_ff == POS_BITS) |->
         (bit_ff <= BIT_ACK && phase_ff != 2'd3 &&
          (bit_ff != BIT_ACK || phase_ff == PHASE_FALL)))
      else $error("bit position out of range");

   a_txn_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (txn_ff <= txn_last))
      else $error("transaction index beyond last");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (fire && done) |=> !busy_ff)
      else $error("still busy after done");

endmodule

`default_nettype wire

FILE: rtl/oled_i2c_write_sequencer_core.sv
`default_nettype none

// Channel   Ports                        Direction  Word
// request   req_valid/req_ready          in         func, value, page, column
// response  rsp_valid/rsp_ready          out        scl, sda, busy_res, rejected, done_res
// config    csr_we/csr_index/csr_wdata   in         device_address (0), ticks_per_wait (1)
//
// One word per clock cycle sustained while rsp_ready stays high; every request word yields one response word.
// A word is registered in the front queue, then passes through the sequencer step
// into the output register.
// Reset is synchronous; no clearing pass follows it.
// A stalled response holds in the output register; the queue then fills and
// req_ready drops.

module oled_i2c_write_sequencer_core #(
   parameter int unsigned QueueDepth = oled_i2c_pkg::QUEUE_DEPTH
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_ready,
   input  wire oled_i2c_pkg::req_payload_type            req_payload,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_ready,
   output oled_i2c_pkg::rsp_payload_type                 rsp_payload,
   input  wire logic                                     csr_we,
   input  wire logic [oled_i2c_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [oled_i2c_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic                      q_valid;
   logic                      q_pop;
   oled_i2c_pkg::q_entry_type q_entry;

   // accept and classify
   oled_i2c_front #(
      .Depth (QueueDepth)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop)
   );

   // bus sequencer and output stage
   oled_i2c_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: dv/tb_oled_i2c_write_sequencer_core.sv
`timescale 1ns / 1ps

module tb_oled_i2c_write_sequencer_core;

   localparam int unsigned STEPS_PER_XACT    = 78;
   localparam int unsigned STEPS_PER_BYTE    = 25;
   localparam int unsigned WORDS_PER_PHASE   = 85;
   localparam int unsigned PHASES            = 6;
   localparam int          PRESSURE_PHASE    = 4;
   localparam int unsigned LONG_STALL_CYCLES = 300;
   localparam int unsigned DRAIN_LIMIT       = 20000;
   localparam int unsigned SETTLE_CYCLES     = 4;
   localparam int unsigned RUN_LIMIT_NS      = 5000000;

   // one row of the directed table; want is used only when typed is set
   typedef struct {
      oled_i2c_pkg::req_payload_type word;
      int unsigned                   reps;
      bit                            typed;
      oled_i2c_pkg::rsp_payload_type want;
   } stim_row_type;

   logic                                     clock;
   logic                                     reset;
   logic                                     req_valid;
   logic                                     req_ready;
   oled_i2c_pkg::req_payload_type            req_payload;
   logic                                     rsp_valid;
   logic                                     rsp_ready;
   oled_i2c_pkg::rsp_payload_type            rsp_payload;
   logic                                     csr_we;
   logic [oled_i2c_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [oled_i2c_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;

   oled_i2c_write_sequencer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // pin sequencer mirror: registers and stepping state
   logic [7:0]  addr_reg;
   logic [15:0] wait_reg;
   logic        seq_busy;
   logic [6:0]  seq_step;
   logic [15:0] seq_wait;
   logic [1:0]  seq_byte;
   logic [1:0]  seq_xact;
   logic [1:0]  seq_last_xact;
   logic [7:0]  frame_bytes [3];
   logic        seq_data_mode;
   logic        pin_scl;
   logic        pin_sda;

   oled_i2c_pkg::rsp_payload_type pending_rsp [$];
   stim_row_type                  directed_rows [$];
   oled_i2c_pkg::rsp_payload_type head_rsp;
   int              error_count = 0;
   int unsigned     send_gap_pct = 0;
   int unsigned     recv_gap_pct = 0;
   int              phase_id = -1;
   bit              long_stall_done = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("oled_i2c_write_sequencer_core test failed");
      $finish;
   end

   function automatic void reset_sequencer_mirror();
      addr_reg       = oled_i2c_pkg::DEFAULT_DEVICE_ADDRESS;
      wait_reg       = oled_i2c_pkg::DEFAULT_TICKS_PER_WAIT;
      seq_busy       = 1'b0;
      seq_step       = '0;
      seq_wait       = '0;
      seq_byte       = '0;
      seq_xact       = '0;
      seq_last_xact  = '0;
      frame_bytes[0] = '0;
      frame_bytes[1] = '0;
      frame_bytes[2] = '0;
      seq_data_mode  = 1'b0;
      pin_scl        = 1'b1;
      pin_sda        = 1'b1;
   endfunction

   // byte on the wire: address, control, then the payload of this transaction
   function automatic logic [7:0] wire_byte();
      case (seq_byte)
         2'd0: return addr_reg;
         2'd1: return seq_data_mode ? oled_i2c_pkg::CTRL_DATA : oled_i2c_pkg::CTRL_COMMAND;
         default: return frame_bytes[seq_xact];
      endcase
   endfunction

   // drive the pins for the current step and reload the wait
   function automatic void show_step();
      int unsigned r;
      int unsigned k;
      logic [7:0]  b;
      if (seq_step == 0) begin
         pin_scl = 1'b1;
         pin_sda = 1'b1;
      end else if (seq_step == 1) begin
         pin_sda = 1'b0;
      end else if (seq_step < STEPS_PER_XACT - 1) begin
         r = seq_step - 2;
         k = r % STEPS_PER_BYTE;
         seq_byte = 2'(r / STEPS_PER_BYTE);
         if (k == STEPS_PER_BYTE - 1) begin
            // ACK clock, sda left alone
            pin_scl = 1'b1;
         end else if (k % 3 == 0) begin
            b = wire_byte();
            pin_scl = 1'b0;
            pin_sda = b[7 - k / 3];
         end else begin
            pin_scl = (k % 3 == 1);
         end
      end else begin
         // stop setup
         pin_scl = 1'b1;
         pin_sda = 1'b0;
      end
      seq_wait = (wait_reg == 0) ? 16'd1 : wait_reg;
   endfunction

   // one tick while busy; returns 1 when the operation completes
   function automatic bit step_tick();
      if (seq_wait > 1) begin
         seq_wait--;
         return 1'b0;
      end
      if (seq_step < STEPS_PER_XACT - 1) begin
         seq_step++;
         show_step();
         return 1'b0;
      end
      if (seq_xact < seq_last_xact) begin
         seq_xact++;
         seq_step = '0;
         seq_byte = '0;
         show_step();
         return 1'b0;
      end
      pin_scl  = 1'b1;
      pin_sda  = 1'b1;
      seq_busy = 1'b0;
      seq_step = '0;
      seq_byte = '0;
      seq_wait = '0;
      return 1'b1;
   endfunction

   function automatic oled_i2c_pkg::rsp_payload_type predict_pins(
      input oled_i2c_pkg::req_payload_type w);
      oled_i2c_pkg::rsp_payload_type r;
      r = '0;
      if (w.func != oled_i2c_pkg::OP_TICK && !seq_busy) begin
         if (w.func == oled_i2c_pkg::OP_CURSOR) begin
            frame_bytes[0] = oled_i2c_pkg::PAGE_CMD | {5'd0, w.page};
            frame_bytes[1] = oled_i2c_pkg::COL_HIGH_CMD | {5'd0, w.column[6:4]};
            frame_bytes[2] = {4'd0, w.column[3:0]};
            seq_last_xact  = 2'd2;
            seq_data_mode  = 1'b0;
         end else begin
            frame_bytes[0] = w.value;
            seq_last_xact  = 2'd0;
            seq_data_mode  = (w.func == oled_i2c_pkg::OP_DATA);
         end
         seq_xact = '0;
         seq_step = '0;
         seq_byte = '0;
         seq_busy = 1'b1;
         show_step();
      end else begin
         // busy requests are dropped but still tick the sequence
         r.rejected = (w.func != oled_i2c_pkg::OP_TICK);
         if (seq_busy)
            r.done_res = step_tick();
      end
      r.scl      = pin_scl;
      r.sda      = pin_sda;
      r.busy_res = seq_busy;
      return r;
   endfunction

   function automatic void add_row(input oled_i2c_pkg::op_kind_type op,
                                   input logic [7:0] value,
                                   input logic [2:0] page, input logic [6:0] column,
                                   input int unsigned reps, input bit typed,
                                   input oled_i2c_pkg::rsp_payload_type want);
      stim_row_type row;
      row.word.func   = op;
      row.word.value  = value;
      row.word.page   = page;
      row.word.column = column;
      row.reps        = reps;
      row.typed       = typed;
      row.want        = want;
      directed_rows.push_back(row);
   endfunction

   // offer one word, predict it once accepted
   task automatic send_word(input oled_i2c_pkg::req_payload_type w, input bit typed,
                            input oled_i2c_pkg::rsp_payload_type want);
      oled_i2c_pkg::rsp_payload_type p;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      p = predict_pins(w);
      pending_rsp.push_back(typed ? want : p);
      @(negedge clock);
   endtask

   task automatic drain_words();
      req_valid <= 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && pending_rsp.size() != 0; n++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [oled_i2c_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [oled_i2c_pkg::CSR_DATA_WIDTH-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      if (idx == oled_i2c_pkg::CSR_DEVICE_ADDRESS)
         addr_reg = data[7:0];
      else
         wait_reg = data;
   endtask

   function automatic void check_bit(input string name, input logic want, input logic got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, want, got);
         error_count++;
      end
   endfunction

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected word, expected none, got %b", $time, rsp_payload);
            error_count++;
         end else begin
            head_rsp = pending_rsp.pop_front();
            check_bit("scl", head_rsp.scl, rsp_payload.scl);
            check_bit("sda", head_rsp.sda, rsp_payload.sda);
            check_bit("busy_res", head_rsp.busy_res, rsp_payload.busy_res);
            check_bit("rejected", head_rsp.rejected, rsp_payload.rejected);
            check_bit("done_res", head_rsp.done_res, rsp_payload.done_res);
         end
      end
   end

   // receiver: random stalls, plus one long hold-off to back up the input
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!long_stall_done && phase_id == PRESSURE_PHASE) begin
            long_stall_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_STALL_CYCLES) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
         end
      end
   end

   initial begin
      oled_i2c_pkg::req_payload_type w;
      logic [7:0]      addr_val;
      logic [15:0]     wait_val;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      reset_sequencer_mirror();

      // directed table at reset settings (address 0x78, one tick per wait)
      // want bits: scl sda busy_res rejected done_res
      add_row(oled_i2c_pkg::OP_TICK,    8'hFF, 3'd7, 7'h7F, 1,   1'b1, 5'b11000);
      add_row(oled_i2c_pkg::OP_TICK,    8'h00, 3'd0, 7'h00, 1,   1'b1, 5'b11000);
      add_row(oled_i2c_pkg::OP_COMMAND, 8'hFF, 3'd0, 7'h00, 1,   1'b1, 5'b11100);
      add_row(oled_i2c_pkg::OP_TICK,    8'h00, 3'd0, 7'h00, 1,   1'b1, 5'b10100);
      // requests while busy are rejected and still advance the bits
      add_row(oled_i2c_pkg::OP_DATA,    8'h00, 3'd0, 7'h00, 1,   1'b1, 5'b00110);
      add_row(oled_i2c_pkg::OP_CURSOR,  8'h00, 3'd7, 7'h7F, 1,   1'b1, 5'b10110);
      add_row(oled_i2c_pkg::OP_TICK,    8'h00, 3'd0, 7'h00, 1,   1'b1, 5'b00100);
      add_row(oled_i2c_pkg::OP_TICK,    8'h00, 3'd0, 7'h00, 73,  1'b0, '0);
      add_row(oled_i2c_pkg::OP_TICK,    8'h00, 3'd0, 7'h00, 1,   1'b1, 5'b11001);
      add_row(oled_i2c_pkg::OP_DATA,    8'h00, 3'd0, 7'h00, 1,   1'b1, 5'b11100);
      add_row(oled_i2c_pkg::OP_TICK,    8'h5A, 3'd5, 7'h2A, 77,  1'b0, '0);
      add_row(oled_i2c_pkg::OP_TICK,    8'h00, 3'd0, 7'h00, 1,   1'b1, 5'b11001);
      add_row(oled_i2c_pkg::OP_CURSOR,  8'h00, 3'd0, 7'h00, 1,   1'b1, 5'b11100);
      add_row(oled_i2c_pkg::OP_COMMAND, 8'h5A, 3'd0, 7'h00, 1,   1'b1, 5'b10110);
      add_row(oled_i2c_pkg::OP_TICK,    8'h00, 3'd0, 7'h00, 232, 1'b0, '0);
      add_row(oled_i2c_pkg::OP_TICK,    8'h00, 3'd0, 7'h00, 1,   1'b1, 5'b11001);
      add_row(oled_i2c_pkg::OP_CURSOR,  8'hFF, 3'd7, 7'h7F, 1,   1'b1, 5'b11100);
      add_row(oled_i2c_pkg::OP_TICK,    8'h00, 3'd0, 7'h00, 233, 1'b0, '0);
      add_row(oled_i2c_pkg::OP_TICK,    8'h00, 3'd0, 7'h00, 1,   1'b1, 5'b11001);
      add_row(oled_i2c_pkg::OP_COMMAND, 8'h00, 3'd0, 7'h00, 1,   1'b1, 5'b11100);
      add_row(oled_i2c_pkg::OP_TICK,    8'h00, 3'd0, 7'h00, 77,  1'b0, '0);
      add_row(oled_i2c_pkg::OP_TICK,    8'h00, 3'd0, 7'h00, 1,   1'b1, 5'b11001);
      add_row(oled_i2c_pkg::OP_DATA,    8'hFF, 3'd0, 7'h00, 1,   1'b1, 5'b11100);
      add_row(oled_i2c_pkg::OP_TICK,    8'h00, 3'd0, 7'h00, 77,  1'b0, '0);
      add_row(oled_i2c_pkg::OP_TICK,    8'h00, 3'd0, 7'h00, 1,   1'b1, 5'b11001);
      add_row(oled_i2c_pkg::OP_TICK,    8'h00, 3'd0, 7'h00, 1,   1'b1, 5'b11000);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_gap_pct = 37;
      recv_gap_pct = 60;
      foreach (directed_rows[i])
         repeat (directed_rows[i].reps)
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

      // longest wait, junk in the unused address bits; idle ticks only
      drain_words();
      write_reg(oled_i2c_pkg::CSR_DEVICE_ADDRESS, 16'hA5FF);
      write_reg(oled_i2c_pkg::CSR_TICKS_PER_WAIT, 16'hFFFF);
      repeat (4) begin
         w.func   = oled_i2c_pkg::OP_TICK;
         w.value  = 8'($urandom_range(255));
         w.page   = 3'($urandom_range(7));
         w.column = 7'($urandom_range(127));
         send_word(w, 1'b0, '0);
      end

      // random phases: mostly whole operations with busy-time noise
      for (int ph = 0; ph < PHASES; ph++) begin
         drain_words();
         case (ph)
            0: begin addr_val = 8'hFF; wait_val = 16'd0; end
            1: begin addr_val = 8'h00; wait_val = 16'd2; end
            2: begin addr_val = 8'($urandom_range(255)); wait_val = 16'd1; end
            3: begin addr_val = 8'($urandom_range(255)); wait_val = 16'd3; end
            4: begin addr_val = oled_i2c_pkg::DEFAULT_DEVICE_ADDRESS; wait_val = 16'd1; end
            default: begin
               addr_val = 8'($urandom_range(255));
               wait_val = 16'($urandom_range(2, 1));
            end
         endcase
         write_reg(oled_i2c_pkg::CSR_DEVICE_ADDRESS, {8'($urandom_range(255)), addr_val});
         write_reg(oled_i2c_pkg::CSR_TICKS_PER_WAIT, wait_val);
         case (ph / 2)
            0: begin send_gap_pct = 37; recv_gap_pct = 60; end
            1: begin send_gap_pct = 60; recv_gap_pct = 37; end
            default: begin send_gap_pct = 0; recv_gap_pct = 0; end
         endcase
         phase_id = ph;
         repeat (WORDS_PER_PHASE) begin
            w.value  = 8'($urandom_range(255));
            w.page   = 3'($urandom_range(7));
            w.column = 7'($urandom_range(127));
            if (seq_busy ? ($urandom_range(99) < 8) : ($urandom_range(99) < 75))
               w.func = 2'($urandom_range(3, 1));
            else
               w.func = oled_i2c_pkg::OP_TICK;
            send_word(w, 1'b0, '0);
         end
      end

      drain_words();
      if (pending_rsp.size() != 0) begin
         $display("%0t: words never returned, expected 0 pending, got %0d",
                  $time, pending_rsp.size());
         error_count++;
      end
      if (error_count == 0)
         $display("oled_i2c_write_sequencer_core test passed");
      else
         $display("oled_i2c_write_sequencer_core test failed");
      $finish;
   end

endmodule

FILE: sim.f
rtl/oled_i2c_pkg.sv
rtl/oled_i2c_front.sv
rtl/oled_i2c_back.sv
rtl/oled_i2c_write_sequencer_core.sv
dv/tb_oled_i2c_write_sequencer_core.sv
